// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the pairing checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spc assertion failed");
`define SPC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("spc forbidden condition");
`else
`define SPC_ASSERT(lbl, prop)
`define SPC_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hw/rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Types and codes of the sync pairing checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package spc_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam logic [2:0] ACT_SET     = 3'd0;
  localparam logic [2:0] ACT_WAIT    = 3'd1;
  localparam logic [2:0] ACT_GET     = 3'd2;
  localparam logic [2:0] ACT_RELEASE = 3'd3;
  localparam logic [2:0] ACT_FLUSH   = 3'd4;

  localparam logic [2:0] RSN_DUP        = 3'd0;
  localparam logic [2:0] RSN_UNMATCHED  = 3'd1;
  localparam logic [2:0] RSN_UNCONSUMED = 3'd2;
  localparam logic [2:0] RSN_DONE       = 3'd3;
  localparam logic [2:0] RSN_FULL       = 3'd4;

  typedef enum logic [1:0] {
    K_OPEN,
    K_CLOSE,
    K_FLUSH
  } kind_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] launch_id;
    logic [3:0]  src_pipe;
    logic [3:0]  dst_pipe;
    logic [2:0]  buf_mode;
    logic [7:0]  object_id;
    logic [5:0]  core_id;
    logic [47:0] event_pc;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  reason;
    logic        is_buffer;
    logic [15:0] rep_launch;
    logic [3:0]  rep_src_pipe;
    logic [3:0]  rep_dst_pipe;
    logic [2:0]  rep_mode;
    logic [7:0]  rep_object;
    logic [47:0] trigger_pc;
    logic        related_valid;
    logic [47:0] related_pc;
    logic [5:0]  pending_count;
    logic        last;
  } out_word_t;

  typedef struct packed {
    kind_t       kind;
    logic        is_buffer;
    logic        by_core;
    logic [15:0] launch;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [2:0]  mode;
    logic [7:0]  object;
    logic [5:0]  core;
    logic [47:0] pc;
  } cmd_t;

endpackage

// ===== hw/rtl/spc_front.sv =====
// ----------------------------------------------------------------------------
// spc_front
// Accept input words, decode them into commands and queue them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module spc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spc_pkg::in_word_t in_data,
  output logic              q_valid,
  output spc_pkg::cmd_t     q_cmd,
  input  logic              q_pop
);
  import spc_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] q_cnt_r;
  cmd_t       dec;
  logic       known;
  logic       push;

  always_comb begin
    dec           = '0;
    known         = 1'b1;
    dec.launch    = in_data.launch_id;
    dec.dst       = in_data.dst_pipe;
    dec.object    = in_data.object_id;
    dec.core      = in_data.core_id;
    dec.pc        = in_data.event_pc;
    dec.kind      = K_OPEN;
    case (in_data.action)
      ACT_SET: begin
        dec.src = in_data.src_pipe;
      end
      ACT_WAIT: begin
        dec.kind = K_CLOSE;
        dec.src  = in_data.src_pipe;
      end
      ACT_GET: begin
        dec.is_buffer = 1'b1;
        dec.by_core   = 1'b1;
        dec.mode      = in_data.buf_mode;
      end
      ACT_RELEASE: begin
        dec.kind      = K_CLOSE;
        dec.is_buffer = 1'b1;
        dec.mode      = in_data.buf_mode;
      end
      ACT_FLUSH: begin
        dec.kind = K_FLUSH;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign in_ready = (q_cnt_r != 2'd2);
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (q_cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

endmodule

// ===== hw/rtl/spc_back.sv =====
// ----------------------------------------------------------------------------
// spc_back
// Match commands against the pending table, update it and emit reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spc_back #(
  parameter int TABLE_DEPTH = spc_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  spc_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output spc_pkg::out_word_t out_data
);
  import spc_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOOK,
    B_ACT,
    B_WALK,
    B_DONE
  } bstate_t;

  typedef struct packed {
    logic        is_buffer;
    logic [15:0] launch;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [2:0]  mode;
    logic [7:0]  object;
    logic [5:0]  core;
    logic [47:0] pc;
  } entry_t;

  bstate_t                state_r;
  cmd_t                   cmd_r;
  entry_t                 tbl_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] hit_vec_r;
  logic [TABLE_DEPTH-1:0] match;
  logic [IW-1:0]          walk_idx_r;
  logic [CW-1:0]          count_r;
  logic                   out_valid_r;
  out_word_t              out_r;
  logic                   out_free;
  logic                   hit_any;
  logic [IW-1:0]          hit_idx;
  logic                   free_any;
  logic [IW-1:0]          free_idx;
  logic [IW-1:0]          rd_idx;
  entry_t                 rd_ent;
  out_word_t              rep;
  logic                   out_load;
  out_word_t              out_nxt;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (state_r == B_IDLE) && q_valid;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = valid_r[i] && (tbl_r[i].is_buffer == cmd_r.is_buffer) &&
                 (tbl_r[i].launch == cmd_r.launch) &&
                 (tbl_r[i].object == cmd_r.object) &&
                 (cmd_r.by_core ? (tbl_r[i].core == cmd_r.core) :
                  (tbl_r[i].src == cmd_r.src && tbl_r[i].dst == cmd_r.dst &&
                   tbl_r[i].mode == cmd_r.mode));
    end
  end

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (hit_vec_r[i]) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign rd_idx = (state_r == B_WALK) ? walk_idx_r : hit_idx;
  assign rd_ent = tbl_r[rd_idx];

  always_comb begin
    rep               = '0;
    rep.is_buffer     = cmd_r.is_buffer;
    rep.rep_launch    = cmd_r.launch;
    rep.rep_src_pipe  = cmd_r.src;
    rep.rep_dst_pipe  = cmd_r.dst;
    rep.rep_mode      = cmd_r.mode;
    rep.rep_object    = cmd_r.object;
    rep.trigger_pc    = cmd_r.pc;
    rep.pending_count = 6'(count_r);
  end

  always_comb begin
    out_load = 1'b0;
    out_nxt  = rep;
    case (state_r)
      B_ACT: begin
        if (out_free) begin
          if (cmd_r.kind == K_OPEN) begin
            if (hit_any) begin
              out_load              = 1'b1;
              out_nxt.reason        = RSN_DUP;
              out_nxt.related_valid = 1'b1;
              out_nxt.related_pc    = rd_ent.pc;
            end else if (!free_any) begin
              out_load       = 1'b1;
              out_nxt.reason = RSN_FULL;
            end
          end else if (!hit_any) begin
            out_load       = 1'b1;
            out_nxt.reason = RSN_UNMATCHED;
          end
        end
      end
      B_WALK: begin
        if (out_free && valid_r[walk_idx_r]) begin
          out_load             = 1'b1;
          out_nxt              = '0;
          out_nxt.reason       = RSN_UNCONSUMED;
          out_nxt.is_buffer    = rd_ent.is_buffer;
          out_nxt.rep_launch   = rd_ent.launch;
          out_nxt.rep_src_pipe = rd_ent.src;
          out_nxt.rep_dst_pipe = rd_ent.dst;
          out_nxt.rep_mode     = rd_ent.mode;
          out_nxt.rep_object   = rd_ent.object;
          out_nxt.trigger_pc   = rd_ent.pc;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_nxt        = '0;
          out_nxt.reason = RSN_DONE;
          out_nxt.last   = 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      walk_idx_r  <= '0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      if (out_load) begin
        out_r <= out_nxt;
      end
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            cmd_r      <= q_cmd;
            walk_idx_r <= '0;
            state_r    <= (q_cmd.kind == K_FLUSH) ? B_WALK : B_LOOK;
          end
        end
        B_LOOK: begin
          hit_vec_r <= match;
          state_r   <= B_ACT;
        end
        B_ACT: begin
          if (cmd_r.kind == K_OPEN) begin
            if (hit_any || !free_any) begin
              if (out_free) begin
                state_r <= B_IDLE;
              end
            end else begin
              valid_r[free_idx] <= 1'b1;
              tbl_r[free_idx]   <= '{cmd_r.is_buffer, cmd_r.launch, cmd_r.src,
                                     cmd_r.dst, cmd_r.mode, cmd_r.object,
                                     cmd_r.core, cmd_r.pc};
              count_r <= count_r + CW'(1);
              state_r <= B_IDLE;
            end
          end else if (hit_any) begin
            valid_r[hit_idx] <= 1'b0;
            count_r          <= count_r - CW'(1);
            state_r          <= B_IDLE;
          end else if (out_free) begin
            state_r <= B_IDLE;
          end
        end
        B_WALK: begin
          if (!valid_r[walk_idx_r] || out_free) begin
            if (valid_r[walk_idx_r]) begin
              valid_r[walk_idx_r] <= 1'b0;
              count_r             <= count_r - CW'(1);
            end
            if (walk_idx_r == IW'(TABLE_DEPTH - 1)) begin
              state_r <= B_DONE;
            end else begin
              walk_idx_r <= walk_idx_r + IW'(1);
            end
          end
        end
        B_DONE: begin
          if (out_free) begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  `SPC_ASSERT_NEVER(a_count_range, count_r > CW'(TABLE_DEPTH))
  `SPC_ASSERT(a_count_matches, $countones(valid_r) == int'(count_r))
  `SPC_ASSERT(a_flush_empties, (state_r == B_DONE && out_free) |=> (valid_r == '0))
  `SPC_ASSERT(a_last_is_done, (out_valid_r && out_r.last) |-> (out_r.reason == RSN_DONE))

endmodule

// ===== hw/rtl/sync_pairing_checker_core.sv =====
// ----------------------------------------------------------------------------
// sync_pairing_checker_core
// Sync event pairing checker with a table of pending opens.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one event word (set, wait, get, release,
//   flush). Unknown actions are accepted and dropped.
//   out_valid/out_ready/out_data carry report words, in event order.
//   A two-word command queue sits between the decoder and the table engine,
//   so input words are taken while reports wait on the output register.
//   Open and close events pass through the engine in steps: dequeue,
//   parallel key match over all entries, then priority pick and table update.
//   A flush walks the table one entry per cycle, holding on a valid entry
//   while the output register holds an untaken report, then emits the done marker.
//   The engine takes a new open or close only once the last one is done.
//   Reset empties the table and the queue directly; no clearing pass.
//   When out_ready is low the engine holds at its next report; the queue
//   fills and then in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sync_pairing_checker_core #(
  parameter int TABLE_DEPTH = spc_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spc_pkg::out_word_t out_data
);
  import spc_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  spc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  spc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
